// ----- rtl/qtp_pkg.sv -----
`default_nettype none
// ============================================================================
// qtp_pkg - shared types and constants for the queued tone player
// Sizes, band limits, prescaler codes, sequencer states and divider structs.
// ============================================================================
package qtp_pkg;

    localparam int QUEUE_DEPTH = 40;
    localparam int CLOCK_HZ    = 16000000;

    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 16;
    localparam int ENTRY_W = FREQ_W + DUR_W;
    localparam int TOP_W   = 8;
    localparam int CODE_W  = 2;
    localparam int COUNT_W = 6;

    localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TAIL_W   = FILL_W + 1;

    // divider: dividend is the clock rate, divisor is 2*f*prescaler
    localparam int DIVIDEND_W = $clog2(CLOCK_HZ + 1);
    localparam int DIVISOR_W  = FREQ_W + 4;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
    localparam int SHIFT_W    = 4;

    // lower edges of the prescaler bands, in Hz
    localparam logic [FREQ_W-1:0] BAND_DIV8_MIN   = FREQ_W'(3906);
    localparam logic [FREQ_W-1:0] BAND_DIV64_MIN  = FREQ_W'(488);
    localparam logic [FREQ_W-1:0] BAND_DIV256_MIN = FREQ_W'(122);

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

    typedef enum logic [CODE_W-1:0] {
        PRESC_DIV8    = 2'd0,
        PRESC_DIV64   = 2'd1,
        PRESC_DIV256  = 2'd2,
        PRESC_DIV1024 = 2'd3
    } t_presc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

    function automatic t_presc presc_band(input logic [FREQ_W-1:0] freq);
        t_presc code;
        if (freq >= BAND_DIV8_MIN) begin
            code = PRESC_DIV8;
        end else if (freq >= BAND_DIV64_MIN) begin
            code = PRESC_DIV64;
        end else if (freq >= BAND_DIV256_MIN) begin
            code = PRESC_DIV256;
        end else begin
            code = PRESC_DIV1024;
        end
        return code;
    endfunction

    // left shift giving 2*f*prescaler from f
    function automatic logic [SHIFT_W-1:0] presc_shift(input t_presc code);
        logic [SHIFT_W-1:0] sh;
        case (code)
            PRESC_DIV8:    sh = SHIFT_W'(4);
            PRESC_DIV64:   sh = SHIFT_W'(7);
            PRESC_DIV256:  sh = SHIFT_W'(9);
            PRESC_DIV1024: sh = SHIFT_W'(11);
            default:       sh = SHIFT_W'(11);
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qtp_item_if.sv -----
`default_nettype none
// ============================================================================
// qtp_item_if - input channel of the tone player
// One beat is a push (frequency, duration) or a one millisecond tick.
// ============================================================================
interface qtp_item_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [qtp_pkg::FREQ_W-1:0]     frequency;
    logic [qtp_pkg::DUR_W-1:0]      duration;

    modport source (output valid, output mode, output frequency, output duration,
                    input ready);
    modport sink   (input valid, input mode, input frequency, input duration,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/qtp_result_if.sv -----
`default_nettype none
// ============================================================================
// qtp_result_if - result channel of the tone player
// One beat per input beat: player status after that item.
// ============================================================================
interface qtp_result_if;
    logic                           valid;
    logic                           ready;
    logic                           playing;
    logic                           tone_on;
    logic [qtp_pkg::CODE_W-1:0]     prescaler_code;
    logic [qtp_pkg::TOP_W-1:0]      compare_top;
    logic [qtp_pkg::COUNT_W-1:0]    queue_count;
    logic                           dropped;

    modport source (output valid, output playing, output tone_on,
                    output prescaler_code, output compare_top, output queue_count,
                    output dropped, input ready);
    modport sink   (input valid, input playing, input tone_on,
                    input prescaler_code, input compare_top, input queue_count,
                    input dropped, output ready);
endinterface
`default_nettype wire

// ----- rtl/qtp_div.sv -----
`default_nettype none
// ============================================================================
// qtp_div - bit-serial restoring divider
// Divides the clock rate by the request divisor, one quotient bit per cycle.
// ============================================================================
module qtp_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire qtp_pkg::t_div_req  i_req,
    output qtp_pkg::t_div_rsp       o_rsp
);

    logic [qtp_pkg::DIVISOR_W-1:0]  r_dvs;
    logic [qtp_pkg::DIVISOR_W-1:0]  r_rem;
    logic [qtp_pkg::DIVIDEND_W-1:0] r_quo;
    logic [qtp_pkg::STEP_W-1:0]     r_cnt;
    logic                           r_run;
    logic                           r_done;

    logic [qtp_pkg::DIVISOR_W:0]    w_trial;
    logic [qtp_pkg::DIVISOR_W+1:0]  w_diff;
    logic                           w_fit;

    // shift in next dividend bit, trial subtract
    assign w_trial = {r_rem, r_quo[qtp_pkg::DIVIDEND_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_fit   = ~w_diff[qtp_pkg::DIVISOR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvs <= i_req.divisor;
                r_rem <= '0;
                r_quo <= qtp_pkg::DIVIDEND_W'(qtp_pkg::CLOCK_HZ);
                r_cnt <= qtp_pkg::STEP_W'(qtp_pkg::DIVIDEND_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= w_fit ? w_diff[qtp_pkg::DIVISOR_W-1:0]
                               : w_trial[qtp_pkg::DIVISOR_W-1:0];
                r_quo <= {r_quo[qtp_pkg::DIVIDEND_W-2:0], w_fit};
                r_cnt <= r_cnt - qtp_pkg::STEP_W'(1);
                if (r_cnt == qtp_pkg::STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ----- rtl/queued_tone_player_core.sv -----
`default_nettype none
// ============================================================================
// queued_tone_player_core - buzzer tone sequencer with a tone queue
// Queues (frequency, duration) tones and works out the CTC timer setting.
// ============================================================================
// Usage:
//  - i_item carries one beat per item: mode 0 pushes a tone, mode 1 is a
//    one millisecond tick. i_item.ready is high only while the sequencer
//    is idle; one item is worked on at a time.
//  - o_result gives exactly one beat per item: playing, timer on/off,
//    prescaler code, compare top, queue fill and a drop flag for pushes.
//  - i_cfg_wr_en / i_cfg_wr_data write the sound enable bit; write only
//    while no item is in flight.
// After acceptance an item passes EXEC and then EMIT when no tone starts;
// START sits before EMIT when the queue runs dry, START and LOAD when a rest
// starts, and START, LOAD and DIV when a tone starts. The next beat can be
// taken in the same cycle as the result goes valid.
// The tone start time is set by the bit-serial divider, one quotient bit
// per cycle over the 24-bit clock rate.
// The result sits in an output register: a stalled receiver does not hold
// off the next input beat, only the emission of the following result.
// Reset (synchronous, active low) empties the queue, stops playback and
// clears the enable bit. Queue entries hold no reset value.
// ============================================================================
module queued_tone_player_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    qtp_item_if.sink        i_item,
    qtp_result_if.source    o_result
);

    // ---------------------------------------------------------------- state
    qtp_pkg::t_state                    r_state, n_state;
    logic                               r_sound_en;

    // captured item
    logic                               r_mode, n_mode;
    logic [qtp_pkg::FREQ_W-1:0]         r_freq, n_freq;
    logic [qtp_pkg::DUR_W-1:0]          r_dur, n_dur;
    logic                               r_dropped, n_dropped;

    // queue pointers
    logic [qtp_pkg::QUEUE_AW-1:0]       r_head, n_head;
    logic [qtp_pkg::FILL_W-1:0]         r_fill, n_fill;

    // playback and timer setting
    logic [qtp_pkg::DUR_W-1:0]          r_rem_ms, n_rem_ms;
    logic                               r_busy, n_busy;
    logic                               r_tone_on, n_tone_on;
    logic [qtp_pkg::CODE_W-1:0]         r_code, n_code;
    logic [qtp_pkg::TOP_W-1:0]          r_top, n_top;

    // result register
    logic                               r_out_valid, n_out_valid;
    logic                               r_out_playing, n_out_playing;
    logic                               r_out_tone_on, n_out_tone_on;
    logic [qtp_pkg::CODE_W-1:0]         r_out_code, n_out_code;
    logic [qtp_pkg::TOP_W-1:0]          r_out_top, n_out_top;
    logic [qtp_pkg::COUNT_W-1:0]        r_out_count, n_out_count;
    logic                               r_out_dropped, n_out_dropped;

    // tone queue memory, 1W1R, registered read
    logic [qtp_pkg::ENTRY_W-1:0]        r_queue_mem [qtp_pkg::QUEUE_DEPTH];
    logic [qtp_pkg::ENTRY_W-1:0]        r_rd_data;
    logic                               w_mem_we;
    logic                               w_mem_re;

    // ------------------------------------------------------------- datapath
    logic                               w_accept;
    logic                               w_emit;
    logic [qtp_pkg::TAIL_W-1:0]         w_tail_sum;
    logic [qtp_pkg::QUEUE_AW-1:0]       w_tail;
    logic                               w_full;
    logic                               w_fill_zero;
    logic                               w_last_ms;
    logic [qtp_pkg::FREQ_W-1:0]         w_rd_freq;
    logic [qtp_pkg::DUR_W-1:0]          w_rd_dur;
    qtp_pkg::t_presc                    w_band;
    qtp_pkg::t_div_req                  w_div_req;
    qtp_pkg::t_div_rsp                  w_div_rsp;

    assign w_accept    = i_item.valid && i_item.ready;
    assign w_emit      = !r_out_valid || o_result.ready;

    // tail = (head + fill) mod depth; the sum stays below twice the depth
    assign w_tail_sum  = qtp_pkg::TAIL_W'(r_head) + qtp_pkg::TAIL_W'(r_fill);
    assign w_tail      = (w_tail_sum >= qtp_pkg::TAIL_W'(qtp_pkg::QUEUE_DEPTH))
                       ? qtp_pkg::QUEUE_AW'(w_tail_sum
                                            - qtp_pkg::TAIL_W'(qtp_pkg::QUEUE_DEPTH))
                       : qtp_pkg::QUEUE_AW'(w_tail_sum);

    assign w_full      = (r_fill >= qtp_pkg::FILL_W'(qtp_pkg::QUEUE_DEPTH));
    assign w_fill_zero = (r_fill == '0);
    assign w_last_ms   = (r_rem_ms <= qtp_pkg::DUR_W'(1));

    // entry: frequency low, duration high
    assign w_rd_freq   = r_rd_data[qtp_pkg::FREQ_W-1:0];
    assign w_rd_dur    = r_rd_data[qtp_pkg::ENTRY_W-1:qtp_pkg::FREQ_W];
    assign w_band      = qtp_pkg::presc_band(w_rd_freq);

    qtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ----------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qtp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = qtp_pkg::S_EXEC;
                end
            end
            qtp_pkg::S_EXEC: begin
                if (!r_sound_en) begin
                    n_state = qtp_pkg::S_EMIT;
                end else if (r_mode == qtp_pkg::MODE_PUSH) begin
                    n_state = r_busy ? qtp_pkg::S_EMIT : qtp_pkg::S_START;
                end else begin
                    n_state = (r_busy && w_last_ms) ? qtp_pkg::S_START
                                                    : qtp_pkg::S_EMIT;
                end
            end
            qtp_pkg::S_START: begin
                n_state = w_fill_zero ? qtp_pkg::S_EMIT : qtp_pkg::S_LOAD;
            end
            qtp_pkg::S_LOAD: begin
                n_state = (w_rd_freq == '0) ? qtp_pkg::S_EMIT : qtp_pkg::S_DIV;
            end
            qtp_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = qtp_pkg::S_EMIT;
                end
            end
            qtp_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_state = qtp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qtp_pkg::S_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        n_mode        = r_mode;
        n_freq        = r_freq;
        n_dur         = r_dur;
        n_dropped     = r_dropped;
        n_head        = r_head;
        n_fill        = r_fill;
        n_rem_ms      = r_rem_ms;
        n_busy        = r_busy;
        n_tone_on     = r_tone_on;
        n_code        = r_code;
        n_top         = r_top;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_playing = r_out_playing;
        n_out_tone_on = r_out_tone_on;
        n_out_code    = r_out_code;
        n_out_top     = r_out_top;
        n_out_count   = r_out_count;
        n_out_dropped = r_out_dropped;
        w_mem_we          = 1'b0;
        w_mem_re          = 1'b0;
        w_div_req.start   = 1'b0;
        w_div_req.divisor = qtp_pkg::DIVISOR_W'(w_rd_freq) << qtp_pkg::presc_shift(w_band);

        case (r_state)
            qtp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode    = i_item.mode;
                    n_freq    = i_item.frequency;
                    n_dur     = i_item.duration;
                    n_dropped = 1'b0;
                end
            end
            qtp_pkg::S_EXEC: begin
                if (r_sound_en) begin
                    if (r_mode == qtp_pkg::MODE_PUSH) begin
                        if (!w_full) begin
                            w_mem_we = 1'b1;
                            n_fill   = r_fill + qtp_pkg::FILL_W'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else if (r_busy && !w_last_ms) begin
                        n_rem_ms = r_rem_ms - qtp_pkg::DUR_W'(1);
                    end
                end
            end
            qtp_pkg::S_START: begin
                if (w_fill_zero) begin
                    // queue ran dry: go idle, timer off
                    n_busy    = 1'b0;
                    n_rem_ms  = '0;
                    n_tone_on = 1'b0;
                    n_code    = '0;
                    n_top     = '0;
                end else begin
                    w_mem_re = 1'b1;
                    n_head   = (r_head == qtp_pkg::QUEUE_AW'(qtp_pkg::QUEUE_DEPTH - 1))
                             ? '0 : r_head + qtp_pkg::QUEUE_AW'(1);
                    n_fill   = r_fill - qtp_pkg::FILL_W'(1);
                    n_busy   = 1'b1;
                end
            end
            qtp_pkg::S_LOAD: begin
                n_rem_ms = w_rd_dur;
                if (w_rd_freq == '0) begin
                    // rest
                    n_tone_on = 1'b0;
                    n_code    = '0;
                    n_top     = '0;
                end else begin
                    n_code          = w_band;
                    w_div_req.start = 1'b1;
                end
            end
            qtp_pkg::S_DIV: begin
                if (w_div_rsp.done) begin
                    // quotient of 0 wraps to 255
                    n_tone_on = 1'b1;
                    n_top     = qtp_pkg::TOP_W'(w_div_rsp.quotient)
                              - qtp_pkg::TOP_W'(1);
                end
            end
            qtp_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_out_valid   = 1'b1;
                    n_out_playing = r_busy;
                    n_out_tone_on = r_tone_on;
                    n_out_code    = r_code;
                    n_out_top     = r_top;
                    n_out_count   = qtp_pkg::COUNT_W'(r_fill);
                    n_out_dropped = r_dropped;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qtp_pkg::S_IDLE;
            r_sound_en  <= 1'b0;
            r_head      <= '0;
            r_fill      <= '0;
            r_rem_ms    <= '0;
            r_busy      <= 1'b0;
            r_tone_on   <= 1'b0;
            r_code      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_sound_en <= i_cfg_wr_data;
            end
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_rem_ms    <= n_rem_ms;
            r_busy      <= n_busy;
            r_tone_on   <= n_tone_on;
            r_code      <= n_code;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_freq        <= n_freq;
        r_dur         <= n_dur;
        r_dropped     <= n_dropped;
        r_out_playing <= n_out_playing;
        r_out_tone_on <= n_out_tone_on;
        r_out_code    <= n_out_code;
        r_out_top     <= n_out_top;
        r_out_count   <= n_out_count;
        r_out_dropped <= n_out_dropped;
    end

    // queue memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_queue_mem[w_tail] <= {r_dur, r_freq};
        end
        if (w_mem_re) begin
            r_rd_data <= r_queue_mem[r_head];
        end
    end

    // ---------------------------------------------------------------- ports
    assign i_item.ready            = (r_state == qtp_pkg::S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.playing        = r_out_playing;
    assign o_result.tone_on        = r_out_tone_on;
    assign o_result.prescaler_code = r_out_code;
    assign o_result.compare_top    = r_out_top;
    assign o_result.queue_count    = r_out_count;
    assign o_result.dropped        = r_out_dropped;

    // ----------------------------------------------------------- assertions
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= qtp_pkg::FILL_W'(qtp_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !r_tone_on)
        else $error("timer on while player idle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == qtp_pkg::S_DIV))
        else $error("divider done outside divide state");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == qtp_pkg::S_EXEC))
        else $error("accepted beat not executed");

endmodule
`default_nettype wire

// ----- tb/tone_status_checker.sv -----
// ============================================================================
// tone_status_checker - scoreboard for the queued tone player
// Watches the item and result channels and the sound-enable writes. Keeps
// its own copy of the tone queue and the player state, works out the status
// each accepted item should produce, and compares every result beat against
// the oldest outstanding prediction.
// ============================================================================
module tone_status_checker
    import qtp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    qtp_item_if       item_mon,
    qtp_result_if     result_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_RATE    = CLOCK_HZ;
    localparam int          MAX_REPORTS = 100;

    typedef struct packed {
        logic               playing;
        logic               tone_on;
        logic [CODE_W-1:0]  code;
        logic [TOP_W-1:0]   top;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } tone_status_t;

    // player model state
    logic [FREQ_W-1:0] q_freq [QUEUE_DEPTH];
    logic [DUR_W-1:0]  q_dur  [QUEUE_DEPTH];
    int unsigned       head;
    int unsigned       fill;
    logic [DUR_W-1:0]  ms_left;
    logic              busy;
    logic              timer_on;
    t_presc            timer_code;
    logic [TOP_W-1:0]  timer_top;
    logic              sound_on;

    tone_status_t expected_status_q[$];

    // pop the oldest tone into the player, or go idle
    function automatic void start_next_tone();
        logic [FREQ_W-1:0] f;
        int unsigned       shift;
        int unsigned       quot;
        timer_on   = 1'b0;
        timer_code = PRESC_DIV8;
        timer_top  = '0;
        if (fill == 0) begin
            busy    = 1'b0;
            ms_left = '0;
            return;
        end
        f       = q_freq[head];
        ms_left = q_dur[head];
        head    = (head + 1) % QUEUE_DEPTH;
        fill    = fill - 1;
        busy    = 1'b1;
        if (f == '0) begin
            return;    // rest: timer stays off
        end
        if (f >= BAND_DIV8_MIN) begin
            timer_code = PRESC_DIV8;
            shift      = 3;
        end else if (f >= BAND_DIV64_MIN) begin
            timer_code = PRESC_DIV64;
            shift      = 6;
        end else if (f >= BAND_DIV256_MIN) begin
            timer_code = PRESC_DIV256;
            shift      = 8;
        end else begin
            timer_code = PRESC_DIV1024;
            shift      = 10;
        end
        quot      = CLK_RATE / ((32'(f) << 1) << shift);
        timer_on  = 1'b1;
        timer_top = TOP_W'(quot - 1);
    endfunction

    function automatic tone_status_t play_item(input logic mode,
                                               input logic [FREQ_W-1:0] freq,
                                               input logic [DUR_W-1:0] dur);
        tone_status_t s;
        int unsigned  slot;
        logic         drop;
        drop = 1'b0;
        if (sound_on) begin
            if (mode == MODE_PUSH) begin
                if (fill < QUEUE_DEPTH) begin
                    slot         = (head + fill) % QUEUE_DEPTH;
                    q_freq[slot] = freq;
                    q_dur[slot]  = dur;
                    fill         = fill + 1;
                end else begin
                    drop = 1'b1;
                end
                if (!busy) begin
                    start_next_tone();
                end
            end else if (busy) begin
                if (ms_left <= 1) begin
                    start_next_tone();
                end else begin
                    ms_left = ms_left - 1'b1;
                end
            end
        end
        s.playing = busy;
        s.tone_on = timer_on;
        s.code    = timer_on ? timer_code : PRESC_DIV8;
        s.top     = timer_on ? timer_top : '0;
        s.count   = COUNT_W'(fill);
        s.dropped = drop;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            o_fail_count = o_fail_count + 1;
            if (o_fail_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        tone_status_t got;
        tone_status_t want;
        if (!i_rst_n) begin
            head     = 0;
            fill     = 0;
            ms_left  = '0;
            busy     = 1'b0;
            timer_on = 1'b0;
            timer_code = PRESC_DIV8;
            timer_top  = '0;
            sound_on   = 1'b0;
            expected_status_q.delete();
        end else begin
            if (result_mon.valid && result_mon.ready) begin
                got.playing = result_mon.playing;
                got.tone_on = result_mon.tone_on;
                got.code    = result_mon.prescaler_code;
                got.top     = result_mon.compare_top;
                got.count   = result_mon.queue_count;
                got.dropped = result_mon.dropped;
                if (expected_status_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: result beat with no item outstanding, expected none, got %h",
                             $time, got);
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("playing",        16'(want.playing), 16'(got.playing));
                    check_field("tone_on",        16'(want.tone_on), 16'(got.tone_on));
                    check_field("prescaler_code", 16'(want.code),    16'(got.code));
                    check_field("compare_top",    16'(want.top),     16'(got.top));
                    check_field("queue_count",    16'(want.count),   16'(got.count));
                    check_field("dropped",        16'(want.dropped), 16'(got.dropped));
                end
            end
            if (item_mon.valid && item_mon.ready) begin
                expected_status_q.push_back(play_item(item_mon.mode, item_mon.frequency,
                                                      item_mon.duration));
            end
            if (i_cfg_wr_en) begin
                sound_on = i_cfg_wr_data;
            end
        end
        o_pending = expected_status_q.size();
    end

endmodule

// ----- tb/tb_queued_tone_player_core.sv -----
// ============================================================================
// tb_queued_tone_player_core - testbench for the queued tone player core
// Drives pushes and millisecond ticks with random gaps and result stalls,
// flips the sound enable between phases, and lets the checker predict and
// compare every result beat. Directed band edges first, then random phases
// that mix tones, fill the queue past full, drain it, and run muted.
// ============================================================================
module tb_queued_tone_player_core;
    timeunit 1ns;
    timeprecision 1ps;

    import qtp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int ITEM_TARGET    = 1750;
    localparam int SETTLE_CYCLES  = 40;     // covers the longest tone start
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    int   fail_count;
    int   pending;
    int   items_played;     // items sent while sound was on
    int   idle_cycles;
    int   stall_left;
    bit   steady_flow;      // phase with no gaps and no stalls
    bit   sound_now;

    qtp_item_if   item_ch ();
    qtp_result_if result_ch ();

    queued_tone_player_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_ch),
        .o_result      (result_ch)
    );

    tone_status_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .item_mon      (item_ch),
        .result_mon    (result_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Length of an idle stretch: mostly none or short, a few long ones.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Frequencies: rests, band edges, each band, and the full 16-bit range.
    function automatic logic [FREQ_W-1:0] pick_frequency();
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 7))
                    0: return 16'd3906;
                    1: return 16'd3905;
                    2: return 16'd488;
                    3: return 16'd487;
                    4: return 16'd122;
                    5: return 16'd121;
                    6: return 16'd1;
                    default: return 16'hFFFF;
                endcase
            end
            2, 3: return FREQ_W'($urandom_range(1, 121));
            4, 5: return FREQ_W'($urandom_range(122, 3905));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    // Short durations keep the queue moving; long ones stay rare.
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return DUR_W'($urandom_range(0, 3));
        end else if (r < 95) begin
            return DUR_W'($urandom_range(4, 20));
        end
        return DUR_W'($urandom_range(21, 200));
    endfunction

    // Receiver: stall stretches of random length between ready cycles.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_left = idle_span();
        end
        result_ch.ready = (stall_left == 0);
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_queued_tone_player_core: FAIL");
            $finish;
        end
    end

    // One item beat. Valid stays high after acceptance so back-to-back
    // beats need no drop; a gap lowers it on a step of its own.
    task automatic send_item(input t_mode mode, input logic [FREQ_W-1:0] freq,
                             input logic [DUR_W-1:0] dur);
        int gap;
        gap = idle_span();
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid     = 1'b0;
            item_ch.mode      = 1'($urandom);
            item_ch.frequency = FREQ_W'($urandom);
            item_ch.duration  = DUR_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.mode      = mode;
        item_ch.frequency = freq;
        item_ch.duration  = dur;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        if (sound_now) begin
            items_played++;
        end
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, FREQ_W'($urandom), DUR_W'($urandom));
    endtask

    // Drop valid, wait for every predicted result, then give the block
    // time to finish a tone start that produces no further beat.
    task automatic wait_quiet();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_sound(input logic enable);
        wait_quiet();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = enable;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sound_now   = enable;
    endtask

    // One random phase: mixed traffic, queue overflow then drain,
    // a run of ticks, or a muted stretch (which may freeze a tone).
    task automatic run_phase();
        int kind;
        int n;
        kind        = $urandom_range(0, 9);
        steady_flow = ($urandom_range(0, 4) == 0);
        set_sound(kind != 9);
        case (kind)
            6, 7: begin
                n = $urandom_range(42, 50);
                repeat (n) send_item(MODE_PUSH, pick_frequency(), pick_duration());
                n = $urandom_range(60, 160);
                repeat (n) send_tick();
            end
            8: begin
                n = $urandom_range(30, 100);
                repeat (n) send_tick();
            end
            9: begin
                n = $urandom_range(10, 30);
                repeat (n) send_item(t_mode'($urandom_range(0, 1)), FREQ_W'($urandom),
                                     DUR_W'($urandom));
            end
            default: begin
                n = $urandom_range(20, 60);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 55) begin
                        send_tick();
                    end else begin
                        send_item(MODE_PUSH, pick_frequency(), pick_duration());
                    end
                end
            end
        endcase
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_PUSH;
        item_ch.frequency = '0;
        item_ch.duration  = '0;
        result_ch.ready   = 1'b0;
        stall_left        = 0;
        steady_flow       = 1'b0;
        sound_now         = 1'b0;
        items_played      = 0;
        idle_cycles       = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Muted: a push and a tick must leave the player untouched.
        set_sound(1'b0);
        send_item(MODE_PUSH, 16'd1000, 16'd5);
        send_tick();

        set_sound(1'b1);
        send_tick();                              // tick while idle
        send_item(MODE_PUSH, 16'd0,     16'd2);   // rest starts right away
        send_item(MODE_PUSH, 16'hFFFF,  16'd0);   // top of div-8 band, zero length
        send_item(MODE_PUSH, 16'd3906,  16'd1);   // band edges on both sides
        send_item(MODE_PUSH, 16'd3905,  16'd1);
        send_item(MODE_PUSH, 16'd488,   16'hFFFF);
        send_item(MODE_PUSH, 16'd487,   16'd0);
        send_item(MODE_PUSH, 16'd122,   16'd1);
        send_item(MODE_PUSH, 16'd121,   16'd1);
        send_item(MODE_PUSH, 16'd1,     16'd1);   // lowest tone, div 1024
        // Rest runs two ticks, then each tick moves to the next tone;
        // the long 488 Hz tone is left to later phases.
        repeat (10) send_tick();

        while (items_played < ITEM_TARGET) begin
            run_phase();
        end

        // Closing phase: full-range durations, only partly played out.
        steady_flow = 1'b0;
        set_sound(1'b1);
        repeat (12) begin
            send_item(MODE_PUSH, pick_frequency(), DUR_W'($urandom));
            send_tick();
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_queued_tone_player_core: PASS");
        end else begin
            $display("tb_queued_tone_player_core: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qtp_pkg.sv
rtl/qtp_item_if.sv
rtl/qtp_result_if.sv
rtl/qtp_div.sv
rtl/queued_tone_player_core.sv
tb/tone_status_checker.sv
tb/tb_queued_tone_player_core.sv
